FILE: rtl/ltpd_pkg.sv
// ----------------------------------------------------------------------------
// ltpd_pkg
// Shared sizes, codes and types of the fountain-code peeling decoder.
// ----------------------------------------------------------------------------
package ltpd_pkg;

  localparam int SYMS    = 16;   // source symbols per block
  localparam int BYTES   = 16;   // bytes per symbol
  localparam int SLOTS   = 64;   // coded packet slots
  localparam int SYM_W   = 4;
  localparam int OFF_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int DEG_W   = 5;
  localparam int CNT_W   = 5;
  localparam int POS_W   = 6;
  localparam int DD_AW   = SYM_W + OFF_W;
  localparam int CD_AW   = SLOT_W + OFF_W;
  localparam int CE_AW   = SLOT_W + SYM_W;
  localparam int ET_AW   = SYM_W + SYM_W;

  typedef enum logic [1:0] {
    OP_PKT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_STORED  = 3'd1,
    ST_NEW     = 3'd2,
    ST_DUP     = 3'd3,
    ST_OVFL    = 3'd4,
    ST_FORMAT  = 3'd5,
    ST_READ    = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ_Q, S_COMMIT, S_OLD_DEG, S_OLD_LOOP, S_OLD_E,
    S_UL_SCAN, S_UL_CMP, S_UL_MOVE, S_CHK, S_LINK, S_COPY,
    S_PEEL_I, S_PEEL_POP, S_PEEL_C, S_XR, S_XW,
    S_DROP_DEG, S_DROP_DQ, S_DROP_SCAN, S_DROP_CMP, S_DROP_MOVE,
    S_AFTER_DROP, S_CONS, S_REG_PKT, S_REG_RD, S_REG_WR, S_DONE
  } eng_state_t;

  typedef enum logic {
    RET_OLD  = 1'b0,
    RET_PEEL = 1'b1
  } ul_ret_t;

  typedef logic [SYMS-1:0][SYM_W-1:0] edges_t;
  typedef logic [BYTES-1:0][7:0]      pdata_t;

  typedef struct packed {
    logic              ok;
    logic [DEG_W-1:0]  degree;
    logic [SLOT_W-1:0] slot;
  } pkt_info_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [2:0]       status;
    logic [CNT_W-1:0] decoded_count;
    logic             all_decoded;
    logic             symbol_valid;
  } result_t;

endpackage

FILE: rtl/ltpd_parser.sv
// ----------------------------------------------------------------------------
// ltpd_parser
// Byte parser: tracks position in the packet, checks its format and
// collects the edge list and the payload.
// ----------------------------------------------------------------------------
module ltpd_parser
  import ltpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic              clear_en,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  input  logic [SLOT_W-1:0] code_slot,
  output pkt_info_t         info,
  output edges_t            edges,
  output pdata_t            pdata
);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic              bad_r, bad_nxt, bad_c;
  logic [DEG_W-1:0]  deg_r, deg_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  edges_t            edges_r, edges_nxt;
  pdata_t            data_r, data_nxt;
  logic              dup;
  logic [SYM_W-1:0]  e_idx;
  logic [OFF_W-1:0]  d_idx;

  always_comb begin
    pos_inc   = (pos_r == '1) ? pos_r : pos_r + POS_W'(1);
    bad_c     = bad_r;
    deg_nxt   = deg_r;
    slot_nxt  = slot_r;
    edges_nxt = edges_r;
    data_nxt  = data_r;
    e_idx     = SYM_W'(pos_r - POS_W'(1));
    d_idx     = OFF_W'(pos_r - POS_W'(1) - POS_W'(deg_r));
    dup       = 1'b0;
    for (int j = 0; j < SYMS; j++) begin
      if (POS_W'(j + 1) < pos_r && edges_r[j] == data_byte[SYM_W-1:0]) dup = 1'b1;
    end
    if (pos_r == '0) begin
      deg_nxt  = data_byte[DEG_W-1:0];
      slot_nxt = code_slot;
      bad_c    = (data_byte == 8'd0) || (data_byte > 8'(SYMS));
    end else if (!bad_r) begin
      if (pos_r <= POS_W'(deg_r)) begin
        if (data_byte >= 8'(SYMS) || dup) begin
          bad_c = 1'b1;
        end else begin
          edges_nxt[e_idx] = data_byte[SYM_W-1:0];
        end
      end else if (pos_r <= POS_W'(deg_r) + POS_W'(BYTES)) begin
        data_nxt[d_idx] = data_byte;
      end else begin
        bad_c = 1'b1;
      end
    end
    if (end_of_packet) begin
      pos_nxt = '0;
      bad_nxt = 1'b0;
    end else begin
      pos_nxt = pos_inc;
      bad_nxt = bad_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_en) begin
      pos_r  <= '0;
      bad_r  <= 1'b0;
      deg_r  <= '0;
      slot_r <= '0;
    end else if (byte_en) begin
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      deg_r  <= deg_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      edges_r <= edges_nxt;
      data_r  <= data_nxt;
    end
  end

  // The length check sees the position that includes the current byte.
  assign info.ok     = !bad_c && (pos_inc == POS_W'(deg_nxt) + POS_W'(BYTES + 1));
  assign info.degree = deg_r;
  assign info.slot   = slot_r;
  assign edges       = edges_r;
  assign pdata       = data_r;

endmodule

FILE: rtl/ltpd_engine.sv
// ----------------------------------------------------------------------------
// ltpd_engine
// Table memories and the sequencer that commits packets, peels decoded
// symbols out of stored packets and serves reads.
// ----------------------------------------------------------------------------
module ltpd_engine
  import ltpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [1:0]       opcode,
  input  logic             end_of_packet,
  input  logic [SYM_W-1:0] read_symbol,
  input  logic [OFF_W-1:0] read_offset,
  input  pkt_info_t        info,
  input  edges_t           edges,
  input  pdata_t           pdata,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output result_t          res
);

  // Memories.
  logic [7:0]        dd_mem  [2**DD_AW];
  logic [7:0]        cd_mem  [2**CD_AW];
  logic [DEG_W-1:0]  deg_mem [SLOTS];
  logic [SYM_W-1:0]  ce_mem  [2**CE_AW];
  logic [SLOT_W-1:0] et_mem  [2**ET_AW];

  logic [DD_AW-1:0]  dd_raddr, dd_waddr;
  logic [7:0]        dd_q, dd_wdata;
  logic              dd_we;
  logic [CD_AW-1:0]  cd_raddr, cd_waddr;
  logic [7:0]        cd_q, cd_wdata;
  logic              cd_we;
  logic [SLOT_W-1:0] deg_raddr, deg_waddr;
  logic [DEG_W-1:0]  deg_q, deg_wdata;
  logic              deg_we;
  logic [CE_AW-1:0]  ce_raddr, ce_waddr;
  logic [SYM_W-1:0]  ce_q, ce_wdata;
  logic              ce_we;
  logic [ET_AW-1:0]  et_raddr, et_waddr;
  logic [SLOT_W-1:0] et_q, et_wdata;
  logic              et_we;

  eng_state_t        state_r, state_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic [SYM_W-1:0]  rs_r, rs_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [SYM_W-1:0]  u_sym_r, u_sym_nxt;
  logic [SYM_W-1:0]  n_r, n_nxt;
  logic [SLOT_W-1:0] c_r, c_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [OFF_W-1:0]  b_r, b_nxt;
  logic [DEG_W-1:0]  deg_r, deg_nxt;
  ul_ret_t           ret_r, ret_nxt;

  logic [SYMS-1:0]            done_r;
  logic [SYM_W-1:0]           list_r [SYMS];
  logic [CNT_W-1:0]           total_r;
  logic [CNT_W-1:0]           ets_r  [SYMS];
  logic [SLOTS-1:0]           dvld_r;

  logic              clear_all;
  logic              reg_sym;
  logic [SYM_W-1:0]  reg_n;
  logic              ets_we;
  logic [SYM_W-1:0]  ets_idx, ets_widx;
  logic [CNT_W-1:0]  ets_rd, ets_wdata;
  logic              dv_set, dv_clr;
  logic [SYM_W-1:0]  cur_edge;
  logic [DEG_W-1:0]  deg_eff;
  logic              ul_more, last_b;

  assign cur_edge = edges[j_r[SYM_W-1:0]];
  assign deg_eff  = dvld_r[c_r] ? deg_q : '0;
  assign last_b   = (b_r == OFF_W'(BYTES - 1));

  always_comb begin
    case (state_r)
      S_UL_SCAN, S_UL_CMP, S_UL_MOVE: ets_idx = u_sym_r;
      S_CHK, S_LINK:                  ets_idx = cur_edge;
      default:                        ets_idx = sym_r;
    endcase
  end
  assign ets_rd  = ets_r[ets_idx];
  assign ul_more = (k_r < ets_rd);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (opcode == OP_READ) begin
            state_nxt = S_READ_Q;
          end else if (opcode == OP_PKT && end_of_packet && info.ok) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ_Q: state_nxt = S_DONE;
      S_COMMIT: begin
        if (info.degree == DEG_W'(1)) begin
          state_nxt = done_r[edges[0]] ? S_DONE : S_REG_PKT;
        end else begin
          state_nxt = S_OLD_DEG;
        end
      end
      S_OLD_DEG:  state_nxt = S_OLD_LOOP;
      S_OLD_LOOP: state_nxt = (j_r < CNT_W'(deg_r)) ? S_OLD_E : S_CHK;
      S_OLD_E:    state_nxt = S_UL_SCAN;
      S_UL_SCAN: begin
        if (ul_more) begin
          state_nxt = S_UL_CMP;
        end else if (ret_r == RET_OLD) begin
          state_nxt = S_OLD_LOOP;
        end else begin
          state_nxt = done_r[n_r] ? S_PEEL_POP : S_REG_RD;
        end
      end
      S_UL_CMP:  state_nxt = (et_q == c_r) ? S_UL_MOVE : S_UL_SCAN;
      S_UL_MOVE: state_nxt = S_UL_SCAN;
      S_CHK: begin
        if (j_r < CNT_W'(info.degree)) begin
          if (ets_rd >= CNT_W'(SYMS)) state_nxt = S_DONE;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK:     if (j_r == CNT_W'(info.degree) - CNT_W'(1)) state_nxt = S_COPY;
      S_COPY:     if (last_b) state_nxt = S_PEEL_I;
      S_PEEL_I:   state_nxt = (i_r < total_r) ? S_PEEL_POP : S_DONE;
      S_PEEL_POP: state_nxt = (ets_rd != '0) ? S_PEEL_C : S_PEEL_I;
      S_PEEL_C:   state_nxt = S_XR;
      S_XR:       state_nxt = S_XW;
      S_XW:       state_nxt = last_b ? S_DROP_DEG : S_XR;
      S_DROP_DEG: state_nxt = S_DROP_DQ;
      S_DROP_DQ:  state_nxt = S_DROP_SCAN;
      S_DROP_SCAN: state_nxt = (j_r < CNT_W'(deg_r)) ? S_DROP_CMP : S_AFTER_DROP;
      S_DROP_CMP: state_nxt = (ce_q == sym_r) ? S_DROP_MOVE : S_DROP_SCAN;
      S_DROP_MOVE: state_nxt = S_AFTER_DROP;
      S_AFTER_DROP: state_nxt = (deg_r == DEG_W'(1)) ? S_CONS : S_PEEL_POP;
      S_CONS:     state_nxt = S_UL_SCAN;
      S_REG_PKT:  if (last_b) state_nxt = S_PEEL_I;
      S_REG_RD:   state_nxt = S_REG_WR;
      S_REG_WR:   state_nxt = last_b ? S_PEEL_POP : S_REG_RD;
      S_DONE:     if (res_take) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    st_nxt    = st_r;
    rd_nxt    = rd_r;
    rs_nxt    = rs_r;
    sym_nxt   = sym_r;
    u_sym_nxt = u_sym_r;
    n_nxt     = n_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    deg_nxt   = deg_r;
    ret_nxt   = ret_r;
    clear_all = 1'b0;
    reg_sym   = 1'b0;
    reg_n     = n_r;
    ets_we    = 1'b0;
    ets_widx  = ets_idx;
    ets_wdata = ets_rd;
    dv_set    = 1'b0;
    dv_clr    = 1'b0;
    dd_raddr  = {sym_r, b_r};
    dd_we     = 1'b0;
    dd_waddr  = {n_r, b_r};
    dd_wdata  = cd_q;
    cd_raddr  = {c_r, b_r};
    cd_we     = 1'b0;
    cd_waddr  = {c_r, b_r};
    cd_wdata  = cd_q ^ dd_q;
    deg_raddr = c_r;
    deg_we    = 1'b0;
    deg_waddr = c_r;
    deg_wdata = deg_r - DEG_W'(1);
    ce_raddr  = {c_r, j_r[SYM_W-1:0]};
    ce_we     = 1'b0;
    ce_waddr  = {c_r, j_r[SYM_W-1:0]};
    ce_wdata  = ce_q;
    et_raddr  = {u_sym_r, k_r[SYM_W-1:0]};
    et_we     = 1'b0;
    et_waddr  = {u_sym_r, k_r[SYM_W-1:0]};
    et_wdata  = et_q;
    case (state_r)
      S_IDLE: begin
        dd_raddr = {read_symbol, read_offset};
        if (acc) begin
          rs_nxt = read_symbol;
          rd_nxt = '0;
          case (opcode)
            OP_PKT:   st_nxt = end_of_packet ? ST_FORMAT : ST_TAKEN;
            OP_READ:  st_nxt = ST_READ;
            OP_CLEAR: begin
              st_nxt    = ST_TAKEN;
              clear_all = 1'b1;
            end
            default:  st_nxt = ST_FORMAT;
          endcase
        end
      end
      S_READ_Q: rd_nxt = done_r[rs_r] ? dd_q : '0;
      S_COMMIT: begin
        c_nxt     = info.slot;
        deg_raddr = info.slot;
        n_nxt     = edges[0];
        b_nxt     = '0;
        j_nxt     = '0;
        ret_nxt   = RET_OLD;
        if (info.degree == DEG_W'(1)) begin
          st_nxt = done_r[edges[0]] ? ST_DUP : ST_NEW;
        end else begin
          st_nxt = ST_STORED;
        end
      end
      S_OLD_DEG: deg_nxt = deg_eff;
      S_OLD_LOOP: begin
        if (j_r >= CNT_W'(deg_r)) begin
          dv_clr = 1'b1;
          j_nxt  = '0;
        end
      end
      S_OLD_E: begin
        u_sym_nxt = ce_q;
        k_nxt     = '0;
      end
      S_UL_SCAN: begin
        if (!ul_more) begin
          if (ret_r == RET_OLD) j_nxt = j_r + CNT_W'(1);
          b_nxt = '0;
        end
      end
      S_UL_CMP: begin
        et_raddr = {u_sym_r, SYM_W'(ets_rd - CNT_W'(1))};
        if (et_q != c_r) k_nxt = k_r + CNT_W'(1);
      end
      S_UL_MOVE: begin
        et_we     = 1'b1;
        ets_we    = 1'b1;
        ets_wdata = ets_rd - CNT_W'(1);
      end
      S_CHK: begin
        if (j_r < CNT_W'(info.degree)) begin
          if (ets_rd >= CNT_W'(SYMS)) st_nxt = ST_OVFL;
          j_nxt = j_r + CNT_W'(1);
        end else begin
          j_nxt = '0;
        end
      end
      S_LINK: begin
        ce_we     = 1'b1;
        ce_wdata  = cur_edge;
        et_we     = 1'b1;
        et_waddr  = {cur_edge, ets_rd[SYM_W-1:0]};
        et_wdata  = c_r;
        ets_we    = 1'b1;
        ets_wdata = ets_rd + CNT_W'(1);
        j_nxt     = j_r + CNT_W'(1);
        if (j_r == CNT_W'(info.degree) - CNT_W'(1)) begin
          deg_we    = 1'b1;
          deg_wdata = info.degree;
          dv_set    = 1'b1;
          b_nxt     = '0;
        end
      end
      S_COPY: begin
        cd_we    = 1'b1;
        cd_wdata = pdata[b_r];
        b_nxt    = b_r + OFF_W'(1);
        if (last_b) i_nxt = '0;
      end
      S_PEEL_I: begin
        if (i_r < total_r) sym_nxt = list_r[i_r[SYM_W-1:0]];
      end
      S_PEEL_POP: begin
        et_raddr = {sym_r, SYM_W'(ets_rd - CNT_W'(1))};
        if (ets_rd != '0) begin
          ets_we    = 1'b1;
          ets_wdata = ets_rd - CNT_W'(1);
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      S_PEEL_C: begin
        c_nxt = et_q;
        b_nxt = '0;
      end
      S_XR: ;
      S_XW: begin
        cd_we = 1'b1;
        b_nxt = b_r + OFF_W'(1);
      end
      S_DROP_DEG: ;
      S_DROP_DQ: begin
        deg_nxt = deg_eff;
        j_nxt   = '0;
      end
      S_DROP_SCAN: ;
      S_DROP_CMP: begin
        ce_raddr = {c_r, SYM_W'(deg_r - DEG_W'(1))};
        if (ce_q != sym_r) j_nxt = j_r + CNT_W'(1);
      end
      S_DROP_MOVE: begin
        ce_we   = 1'b1;
        deg_we  = 1'b1;
        deg_nxt = deg_r - DEG_W'(1);
      end
      S_AFTER_DROP: ce_raddr = {c_r, SYM_W'(0)};
      S_CONS: begin
        dv_clr    = 1'b1;
        n_nxt     = ce_q;
        u_sym_nxt = ce_q;
        k_nxt     = '0;
        ret_nxt   = RET_PEEL;
      end
      S_REG_PKT: begin
        dd_we    = 1'b1;
        dd_wdata = pdata[b_r];
        b_nxt    = b_r + OFF_W'(1);
        if (last_b) begin
          reg_sym = 1'b1;
          i_nxt   = '0;
        end
      end
      S_REG_RD: ;
      S_REG_WR: begin
        dd_we = 1'b1;
        b_nxt = b_r + OFF_W'(1);
        if (last_b) reg_sym = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= '0;
      total_r <= '0;
      dvld_r  <= '0;
      for (int s = 0; s < SYMS; s++) ets_r[s] <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear_all) begin
        done_r  <= '0;
        total_r <= '0;
        dvld_r  <= '0;
        for (int s = 0; s < SYMS; s++) ets_r[s] <= '0;
      end else begin
        if (ets_we) ets_r[ets_widx] <= ets_wdata;
        if (dv_set) dvld_r[c_r] <= 1'b1;
        if (dv_clr) dvld_r[c_r] <= 1'b0;
        if (reg_sym) begin
          done_r[reg_n] <= 1'b1;
          if (total_r < CNT_W'(SYMS)) total_r <= total_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    rd_r    <= rd_nxt;
    rs_r    <= rs_nxt;
    sym_r   <= sym_nxt;
    u_sym_r <= u_sym_nxt;
    n_r     <= n_nxt;
    c_r     <= c_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    b_r     <= b_nxt;
    deg_r   <= deg_nxt;
    ret_r   <= ret_nxt;
    if (reg_sym && total_r < CNT_W'(SYMS)) list_r[total_r[SYM_W-1:0]] <= reg_n;
  end

  always_ff @(posedge clk) begin
    if (dd_we) dd_mem[dd_waddr] <= dd_wdata;
    dd_q <= dd_mem[dd_raddr];
  end

  always_ff @(posedge clk) begin
    if (cd_we) cd_mem[cd_waddr] <= cd_wdata;
    cd_q <= cd_mem[cd_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (ce_we) ce_mem[ce_waddr] <= ce_wdata;
    ce_q <= ce_mem[ce_raddr];
  end

  always_ff @(posedge clk) begin
    if (et_we) et_mem[et_waddr] <= et_wdata;
    et_q <= et_mem[et_raddr];
  end

  assign idle              = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_DONE);
  assign res.read_data     = rd_r;
  assign res.status        = st_r;
  assign res.decoded_count = total_r;
  assign res.all_decoded   = (total_r == CNT_W'(SYMS));
  assign res.symbol_valid  = done_r[rs_r];

  // Every decoded symbol is counted exactly once.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(done_r) == 32'(total_r))
    else $error("decoded count differs from decoded flags");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(SYMS))
    else $error("decoded count above symbol count");

  // Linking is reached only after the overflow check passed for every edge.
  a_link_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LINK |-> ets_rd < CNT_W'(SYMS))
    else $error("edge row full while linking");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_take) |=> state_r == S_DONE && $stable(st_r))
    else $error("pending result dropped");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r != S_IDLE)
    else $error("accepted word produced no result");

endmodule

FILE: rtl/lt_peeling_decoder.sv
// ----------------------------------------------------------------------------
// lt_peeling_decoder
// Fountain-code peeling decoder with byte-wide packet intake and readback.
// ----------------------------------------------------------------------------
// Input words carry an opcode: a packet byte, a read of one decoded byte, or
// a clear of all tables. Every input word yields exactly one output word with
// the status, the decoded count and the read data.
// A packet byte that does not end a packet, a clear or a bad opcode goes
// straight to the result; a read first fetches its byte. The last byte of a
// well-formed packet starts the commit and peel sequencer, whose length grows
// with the work: it stores a payload of 16 bytes, peels each edge (pop, read
// and XOR of 16 bytes, degree update) and scans edge rows and edge lists of
// up to 16 entries each.
// The decoder accepts one word at a time; a finished output word sits in an
// output register, so the next input word is taken while it waits.
// A stalled receiver holds the output register; the sequencer then waits
// with its next result until that register is free.
// Reset (and the clear opcode) empties all tables at once; no sweep is run.
// ----------------------------------------------------------------------------
module lt_peeling_decoder
  import ltpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_packet,
  input  logic [SLOT_W-1:0] in_code_slot,
  input  logic [SYM_W-1:0]  in_read_symbol,
  input  logic [OFF_W-1:0]  in_read_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_read_data,
  output logic [2:0]        out_status,
  output logic [CNT_W-1:0]  out_decoded_count,
  output logic              out_all_decoded,
  output logic              out_symbol_valid
);

  logic      acc, idle, res_valid, res_take, out_free;
  pkt_info_t info;
  edges_t    edges;
  pdata_t    pdata;
  result_t   res, out_r;
  logic      out_valid_r;

  assign in_ready = idle;
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign res_take = res_valid && out_free;

  ltpd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (acc && in_opcode == OP_PKT),
    .clear_en      (acc && in_opcode == OP_CLEAR),
    .data_byte     (in_data_byte),
    .end_of_packet (in_end_of_packet),
    .code_slot     (in_code_slot),
    .info          (info),
    .edges         (edges),
    .pdata         (pdata)
  );

  ltpd_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .opcode        (in_opcode),
    .end_of_packet (in_end_of_packet),
    .read_symbol   (in_read_symbol),
    .read_offset   (in_read_offset),
    .info          (info),
    .edges         (edges),
    .pdata         (pdata),
    .idle          (idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_r.read_data;
  assign out_status        = out_r.status;
  assign out_decoded_count = out_r.decoded_count;
  assign out_all_decoded   = out_r.all_decoded;
  assign out_symbol_valid  = out_r.symbol_valid;

endmodule
